/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge, off while reset is asserted
`define ASSERT_AT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("lbmc assertion failed");

// consequence expected in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbmc assertion failed");

`endif

/* design/lbmc_pkg.sv */
package lbmc_pkg;

	localparam int LINE_W = 6;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int PERIOD_W = 8;

	localparam logic [15:0] ALL_LEDS = 16'hFFFF;

	localparam logic [PERIOD_W-1:0] BLINK_A_RESET = 8'd2;
	localparam logic [PERIOD_W-1:0] BLINK_B_RESET = 8'd8;

	// register select is address bit 2
	localparam int REG_SEL_BIT = 2;
	localparam logic REG_A_IDX = 1'b0;
	localparam logic REG_B_IDX = 1'b1;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;

	typedef enum logic [1:0] {
		MODE_OFF     = 2'd0,
		MODE_BLINK_A = 2'd1,
		MODE_BLINK_B = 2'd2,
		MODE_ON      = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_MODE = 2'd1,
		ST_BAD_LED  = 2'd2,
		ST_BAD_CMD  = 2'd3
	} status_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period_a;
		logic [PERIOD_W-1:0] period_b;
	} cfg_t;

	typedef struct packed {
		logic lit_a;
		logic lit_b;
	} blink_t;

	// a period of zero behaves as a period of one
	function automatic logic [PERIOD_W-1:0] reload_of(input logic [PERIOD_W-1:0] period);
		return (period == '0) ? '0 : period - 1'b1;
	endfunction

endpackage

/* design/lbmc_channels.sv */
interface lbmc_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] led_number;
	logic [15:0] mode_value;

	modport source (output valid, output op, output led_number, output mode_value, input ready);
	modport sink (input valid, input op, input led_number, input mode_value, output ready);
endinterface

interface lbmc_rsp_if;
	logic       valid;
	logic       ready;
	logic [5:0] led_lines;
	logic [1:0] status;

	modport source (output valid, output led_lines, output status, input ready);
	modport sink (input valid, input led_lines, input status, output ready);
endinterface

/* design/led_blink_mode_controller_unit.sv */
// LED blink controller: LED_COUNT LED lines (up to six shown on led_lines), each
// in mode off, on, blink A or blink B. A set transaction (op 1) stores a mode
// for one LED, or for all LEDs with number 0xFFFF; a single LED set to off or
// on switches at once, while setting all LEDs waits for the next tick. A tick
// transaction (op 0) drives every line from its mode, then steps both blink
// counters down, reloading at period-1. Every transaction returns exactly one
// result with the line levels and a status (ok, bad mode, bad LED number, bad
// command). The block takes one transaction per clock cycle while results are
// taken. The work runs between an input register and a result register, which
// offers the result. Input ready is high whenever the input register is empty
// or moving on, which it does when the result register is empty or taken.
// Periods are set over the APB port (A at byte 0, B at byte 4); the user must
// write them only while the block is idle, which the block itself does not
// enforce. A period write does not reload its counter.
`include "assert_macros.svh"

module led_blink_mode_controller_unit #(
	parameter int LED_COUNT = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	lbmc_req_if.sink                    req,
	lbmc_rsp_if.source                  rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbmc_pkg::ADDR_W-1:0] paddr,
	input  logic [lbmc_pkg::DATA_W-1:0] pwdata,
	output logic [lbmc_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import lbmc_pkg::*;

	// input register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] led_number_s1;
	logic [15:0] mode_value_s1;

	// result register
	logic              rsp_valid_q;
	logic [LINE_W-1:0] led_lines_s2;
	status_t           status_s2;

	logic              adv;
	logic              tick;
	cfg_t              cfg;
	blink_t            blink;
	logic [LINE_W-1:0] lines_next;
	status_t           status_next;

	// rejected transactions leaving stage 1, used by the checks below
	logic              bad_mode_adv;
	logic              bad_cmd_adv;

	// stage 1 hands its transaction to the result register
	assign adv       = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;
	assign tick      = adv && (op_s1 == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			op_s1         <= req.op;
			led_number_s1 <= req.led_number;
			mode_value_s1 <= req.mode_value;
		end
	end

	lbmc_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lbmc_blink_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.tick   (tick),
		.blink  (blink)
	);

	lbmc_led_bank #(
		.LED_COUNT (LED_COUNT)
	) u_bank (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (adv),
		.op         (op_s1),
		.led_number (led_number_s1),
		.mode_value (mode_value_s1),
		.blink      (blink),
		.led_lines  (lines_next),
		.status     (status_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// led_lines_s2 is reset so it always mirrors the stored line levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_lines_s2 <= '0;
			status_s2    <= ST_OK;
		end else if (adv) begin
			led_lines_s2 <= lines_next;
			status_s2    <= status_next;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.led_lines = led_lines_s2;
	assign rsp.status    = status_s2;

	assign bad_mode_adv = adv && (op_s1 == OP_SET) && (mode_value_s1[15:2] != 14'd0);
	assign bad_cmd_adv  = adv && (op_s1 != OP_TICK) && (op_s1 != OP_SET);

	// every transaction leaving stage 1 becomes a visible result
	`ASSERT_NEXT(a_adv_fills_rsp, clk, arst_n, adv, rsp_valid_q)
	// a stalled transaction stays in stage 1 untouched
	`ASSERT_NEXT(a_s1_held, clk, arst_n, valid_s1 && !adv, valid_s1 && $stable(op_s1))
	// bad mode reports and leaves the lines alone
	`ASSERT_NEXT(a_bad_mode, clk, arst_n, bad_mode_adv, status_s2 == ST_BAD_MODE && $stable(led_lines_s2))
	// unsupported command reports and leaves the lines alone
	`ASSERT_NEXT(a_bad_cmd, clk, arst_n, bad_cmd_adv, status_s2 == ST_BAD_CMD && $stable(led_lines_s2))

endmodule

/* design/lbmc_apb_regs.sv */
module lbmc_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lbmc_pkg::ADDR_W-1:0] paddr,
	input  logic [lbmc_pkg::DATA_W-1:0] pwdata,
	output logic [lbmc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output lbmc_pkg::cfg_t              cfg
);
	import lbmc_pkg::*;

	logic [PERIOD_W-1:0] period_a_q;
	logic [PERIOD_W-1:0] period_b_q;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_a_q <= BLINK_A_RESET;
			period_b_q <= BLINK_B_RESET;
		end else if (wr_en) begin
			case (paddr[REG_SEL_BIT])
				REG_A_IDX: period_a_q <= pwdata[PERIOD_W-1:0];
				default:   period_b_q <= pwdata[PERIOD_W-1:0];
			endcase
		end
	end

	always_comb begin
		case (paddr[REG_SEL_BIT])
			REG_A_IDX: prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_a_q};
			default:   prdata = {{(DATA_W-PERIOD_W){1'b0}}, period_b_q};
		endcase
	end

	assign cfg.period_a = period_a_q;
	assign cfg.period_b = period_b_q;

endmodule

/* design/lbmc_blink_timer.sv */
module lbmc_blink_timer (
	input  logic             clk,
	input  logic             arst_n,
	input  lbmc_pkg::cfg_t   cfg,
	input  logic             tick,
	output lbmc_pkg::blink_t blink
);
	import lbmc_pkg::*;

	logic [PERIOD_W-1:0] count_a_q;
	logic [PERIOD_W-1:0] count_b_q;
	logic [PERIOD_W-1:0] reload_a;
	logic [PERIOD_W-1:0] reload_b;

	assign reload_a = reload_of(cfg.period_a);
	assign reload_b = reload_of(cfg.period_b);

	// lit while the down counter sits in the upper half of the cycle
	assign blink.lit_a = count_a_q > (reload_a >> 1);
	assign blink.lit_b = count_b_q > (reload_b >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_a_q <= reload_of(BLINK_A_RESET);
			count_b_q <= reload_of(BLINK_B_RESET);
		end else if (tick) begin
			count_a_q <= (count_a_q == '0) ? reload_a : count_a_q - 1'b1;
			count_b_q <= (count_b_q == '0) ? reload_b : count_b_q - 1'b1;
		end
	end

endmodule

/* design/lbmc_led_bank.sv */
module lbmc_led_bank #(
	parameter int LED_COUNT = 6
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        fire,
	input  logic [1:0]                  op,
	input  logic [15:0]                 led_number,
	input  logic [15:0]                 mode_value,
	input  lbmc_pkg::blink_t            blink,
	output logic [lbmc_pkg::LINE_W-1:0] led_lines,
	output lbmc_pkg::status_t           status
);
	import lbmc_pkg::*;

	localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

	mode_t                modes_q [LED_COUNT];
	mode_t                modes_d [LED_COUNT];
	logic [LED_COUNT-1:0] lines_q;
	logic [LED_COUNT-1:0] lines_d;
	logic                 mode_ok;
	mode_t                req_mode;
	logic [IDX_W-1:0]     led_idx;

	assign mode_ok  = (mode_value[15:2] == 14'd0);
	assign req_mode = mode_t'(mode_value[1:0]);
	assign led_idx  = led_number[IDX_W-1:0];

	always_comb begin
		modes_d = modes_q;
		lines_d = lines_q;
		status  = ST_OK;
		case (op)
			OP_TICK: begin
				for (int i = 0; i < LED_COUNT; i++) begin
					case (modes_q[i])
						MODE_OFF:     lines_d[i] = 1'b0;
						MODE_ON:      lines_d[i] = 1'b1;
						MODE_BLINK_A: lines_d[i] = blink.lit_a;
						default:      lines_d[i] = blink.lit_b;
					endcase
				end
			end
			OP_SET: begin
				if (!mode_ok) begin
					status = ST_BAD_MODE;
				end else if (led_number == ALL_LEDS) begin
					// lines follow on the next tick
					for (int i = 0; i < LED_COUNT; i++) begin
						modes_d[i] = req_mode;
					end
				end else if (led_number >= 16'(LED_COUNT)) begin
					status = ST_BAD_LED;
				end else begin
					modes_d[led_idx] = req_mode;
					if (req_mode == MODE_OFF) begin
						lines_d[led_idx] = 1'b0;
					end else if (req_mode == MODE_ON) begin
						lines_d[led_idx] = 1'b1;
					end
				end
			end
			default: status = ST_BAD_CMD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LED_COUNT; i++) begin
				modes_q[i] <= MODE_OFF;
			end
			lines_q <= '0;
		end else if (fire) begin
			modes_q <= modes_d;
			lines_q <= lines_d;
		end
	end

	for (genvar i = 0; i < LINE_W; i++) begin : g_line
		if (i < LED_COUNT) begin : g_used
			assign led_lines[i] = lines_d[i];
		end else begin : g_unused
			assign led_lines[i] = 1'b0;
		end
	end

endmodule
